[rtl/lpbm_pkg.sv]
// Shared constants and types of the linear congruential generator.
package lpbm_pkg;

	localparam logic [31:0] LCG_MULT      = 32'd214013;
	localparam logic [31:0] LCG_INC       = 32'd2531011;
	localparam logic [31:0] MODULUS_RESET = 32'd2147483647;
	localparam logic [31:0] SEED_RESET    = 32'd1;

	localparam int SEED_W    = 32;
	localparam int OUT_W     = 16;
	localparam int OUT_SHIFT = 16;
	localparam int STEPS     = 32;
	localparam int CNT_W     = $clog2(STEPS);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	typedef enum logic {
		CMD_GEN  = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD_SEED,
		OP_START_MUL,
		OP_MUL_STEP,
		OP_ADD_INC,
		OP_DIV_STEP,
		OP_COMMIT
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_INC,
		ST_DIV,
		ST_WAIT
	} state_t;

	// Sequencer command to the datapath.
	typedef struct packed {
		op_t  op;
	} ctrl_t;

endpackage

[rtl/lpbm_stream_if.sv]
// Valid/ready channel interfaces for requests and results of the generator.
interface lpbm_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] new_seed;

	modport source (output valid, output cmd, output new_seed, input ready);
	modport sink   (input valid, input cmd, input new_seed, output ready);
	modport mon    (input valid, input cmd, input new_seed, input ready);
endinterface

interface lpbm_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink   (input valid, input random_value, output ready);
	modport mon    (input valid, input random_value, input ready);
endinterface

[rtl/lpbm_ctrl.sv]
// Sequencer: step counter and state machine that drives the shared datapath.
module lpbm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_cmd,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lpbm_pkg::ctrl_t ctrl
);
	import lpbm_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	logic             slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && (req_cmd == CMD_GEN)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_INC;
				end
			end
			ST_INC: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ctrl.op   = OP_HOLD;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.op = (req_cmd == CMD_LOAD) ? OP_LOAD_SEED : OP_START_MUL;
				end
			end
			ST_MUL:  ctrl.op = OP_MUL_STEP;
			ST_INC:  ctrl.op = OP_ADD_INC;
			ST_DIV:  ctrl.op = OP_DIV_STEP;
			ST_WAIT: begin
				if (slot_free) begin
					ctrl.op = OP_COMMIT;
				end
			end
			default: ctrl.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_MUL) || (state_q == ST_DIV)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (ctrl.op == OP_COMMIT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/lpbm_datapath.sv]
// Datapath: seed and modulus registers, shared adder, Booth and divider shift registers.
module lpbm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpbm_pkg::ctrl_t             ctrl,
	input  logic                        cfg_we,
	input  logic [lpbm_pkg::SEED_W-1:0] cfg_wdata,
	input  logic [lpbm_pkg::SEED_W-1:0] new_seed,
	output logic [lpbm_pkg::OUT_W-1:0]  random_value
);
	import lpbm_pkg::*;

	logic [SEED_W-1:0] seed_q;
	logic [SEED_W-1:0] modulus_q;
	logic [SEED_W-1:0] acc_q;
	logic [SEED_W-1:0] shreg_q;
	logic              qm1_q;
	logic [OUT_W-1:0]  rand_q;

	logic [SEED_W+1:0] add_a, add_b, add_sum;
	logic              add_sub;

	// Operand selection for the one shared add/subtract unit.
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (ctrl.op)
			OP_MUL_STEP: begin
				add_a   = {{2{acc_q[SEED_W-1]}}, acc_q[SEED_W-1:0]};
				add_sub = shreg_q[0] & ~qm1_q;
				if (shreg_q[0] != qm1_q) begin
					add_b = {2'b00, LCG_MULT};
				end
			end
			OP_ADD_INC: begin
				add_a = {2'b00, shreg_q};
				add_b = {2'b00, LCG_INC};
			end
			OP_DIV_STEP: begin
				add_a   = {1'b0, acc_q[SEED_W-1:0], shreg_q[SEED_W-1]};
				add_b   = {2'b00, modulus_q};
				add_sub = 1'b1;
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(SEED_W+1){1'b0}}, add_sub};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= SEED_RESET;
			modulus_q <= MODULUS_RESET;
		end else begin
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			if (ctrl.op == OP_LOAD_SEED) begin
				seed_q <= new_seed;
			end else if (ctrl.op == OP_COMMIT) begin
				seed_q <= acc_q[SEED_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_START_MUL: begin
				acc_q   <= '0;
				shreg_q <= seed_q;
				qm1_q   <= 1'b0;
			end
			OP_MUL_STEP: begin
				// Arithmetic shift right of {A, Q, q-1} after the add or subtract.
				acc_q   <= {add_sum[SEED_W-1], add_sum[SEED_W-1:1]};
				shreg_q <= {add_sum[0], shreg_q[SEED_W-1:1]};
				qm1_q   <= shreg_q[0];
			end
			OP_ADD_INC: begin
				shreg_q <= add_sum[SEED_W-1:0];
				acc_q   <= '0;
			end
			OP_DIV_STEP: begin
				// Restoring step: keep the difference unless it went negative.
				// Either value is below the modulus, so 32 bits hold it.
				acc_q   <= add_sum[SEED_W+1] ? add_a[SEED_W-1:0] : add_sum[SEED_W-1:0];
				shreg_q <= {shreg_q[SEED_W-2:0], 1'b0};
			end
			OP_COMMIT: begin
				rand_q <= acc_q[OUT_SHIFT+OUT_W-1:OUT_SHIFT];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign random_value = rand_q;

endmodule

[rtl/lcg_prng_booth_multiply_top.sv]
// Top level of the 32-bit linear congruential pseudo-random generator.
//
// Each request on req carries a command: a load-seed request replaces the
// 32-bit seed and produces no result, while a generate request forms
// seed * 214013 (low 32 bits, by 32 radix-2 Booth steps), adds 2531011
// modulo 2^32, and reduces the sum modulo the modulus register by 32
// restoring divide steps. The remainder becomes the new seed and its upper
// sixteen bits are returned on rsp. A generate request runs through a start
// step (in the cycle in which it is accepted), 32 multiply steps, an
// increment step, 32 divide steps and a commit step, all sharing a single
// 34-bit add/subtract unit. Its result appears on rsp after the commit step,
// and the next request can then be accepted. Requests are refused while a
// generate is in progress; load-seed requests are taken back to back.
// A finished result sits in an output register, so a new request may be
// accepted while it waits to be taken, though the next generate holds its
// commit cycle until the output register is free, which adds the length of
// that stall. A modulus of zero leaves the sum unreduced. The modulus is
// written through cfg_we/cfg_wdata and should only change while the block is
// idle; it resets to 2147483647 and the seed resets to 1.
module lcg_prng_booth_multiply_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	lpbm_req_if.sink           req,
	lpbm_rsp_if.source         rsp
);
	import lpbm_pkg::*;

	ctrl_t ctrl;

	// The sequencer owns the handshakes and the step counter.
	lpbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctrl      (ctrl)
	);

	// The datapath holds the seed, the modulus and the shared arithmetic.
	lpbm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.new_seed     (req.new_seed),
		.random_value (rsp.random_value)
	);

endmodule

[rtl/lpbm_checker.sv]
// Port-level assertions for the generator, bound to its top level.
module lpbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_cmd,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] random_value
);
	import lpbm_pkg::*;

	// A waiting result stays put until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(random_value))
		else $error("result changed or vanished while stalled");

	// A generate request keeps the block busy on the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == CMD_GEN) |=> !req_ready)
		else $error("request taken during a generate");

	// A load-seed request finishes at once and leaves the block ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == CMD_LOAD) |=> req_ready)
		else $error("block busy after a load-seed request");

	// A new result never appears right after a request was accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared without computation");

endmodule

bind lcg_prng_booth_multiply_top lpbm_checker u_lpbm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_cmd      (req.cmd),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.random_value (rsp.random_value)
);
